// ----- src/dlc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dlc_pkg
// Shared constants, codes and control types of the linked-list core.
// ============================================================================
package dlc_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int IDX_W      = $clog2(CAPACITY + 1);

    localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

    localparam int IN_W  = 40;   // opcode(5) + value(32), padded to bytes
    localparam int OUT_W = 40;   // read_value(32) + 3 flags, padded to bytes

    typedef enum logic [4:0] {
        OP_CLEAR      = 5'd0,
        OP_INS_FIRST  = 5'd1,
        OP_INS_LAST   = 5'd2,
        OP_CUR_FIRST  = 5'd3,
        OP_CUR_LAST   = 5'd4,
        OP_READ_FIRST = 5'd5,
        OP_READ_LAST  = 5'd6,
        OP_DEL_FIRST  = 5'd7,
        OP_DEL_LAST   = 5'd8,
        OP_DEL_AFTER  = 5'd9,
        OP_DEL_BEFORE = 5'd10,
        OP_INS_AFTER  = 5'd11,
        OP_INS_BEFORE = 5'd12,
        OP_READ_CUR   = 5'd13,
        OP_OVERWRITE  = 5'd14,
        OP_CUR_FWD    = 5'd15,
        OP_CUR_BACK   = 5'd16,
        OP_QUERY      = 5'd17
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_FREE,
        ST_RD_NBR,
        ST_RD_NBR2,
        ST_CAP2,
        ST_WR1,
        ST_WR2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_nbr;
        logic rd_nbr2;
        logic cap2;
        logic wr1;
        logic wr2;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic idx_ok(input logic [IDX_W-1:0] i);
        return (i < IDX_W'(CAPACITY));
    endfunction

endpackage

// ----- src/dlc_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dlc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module dlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/dlc_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dlc_ctrl
// Sequencer: read free link, read neighbor, read second neighbor, capture,
// two write steps, then hand the result to the output register once it is free.
// ============================================================================
module dlc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output dlc_pkg::cmd_t    cmd,
    input  dlc_pkg::status_t status
);

    dlc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dlc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = dlc_pkg::ST_RD_FREE;
                end
            end
            dlc_pkg::ST_RD_FREE: state_next = dlc_pkg::ST_RD_NBR;
            dlc_pkg::ST_RD_NBR:  state_next = dlc_pkg::ST_RD_NBR2;
            dlc_pkg::ST_RD_NBR2: state_next = dlc_pkg::ST_CAP2;
            dlc_pkg::ST_CAP2:    state_next = dlc_pkg::ST_WR1;
            dlc_pkg::ST_WR1:     state_next = dlc_pkg::ST_WR2;
            dlc_pkg::ST_WR2:     state_next = dlc_pkg::ST_DONE;
            dlc_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = dlc_pkg::ST_IDLE;
                end
            end
            default: state_next = dlc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            dlc_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            dlc_pkg::ST_RD_FREE: ;
            dlc_pkg::ST_RD_NBR:  cmd.rd_nbr  = 1'b1;
            dlc_pkg::ST_RD_NBR2: cmd.rd_nbr2 = 1'b1;
            dlc_pkg::ST_CAP2:    cmd.cap2    = 1'b1;
            dlc_pkg::ST_WR1:     cmd.wr1     = 1'b1;
            dlc_pkg::ST_WR2:     cmd.wr2     = 1'b1;
            dlc_pkg::ST_DONE:    cmd.load_out = status.out_free;
            default: ;
        endcase
    end

endmodule

// ----- src/dlc_datapath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dlc_datapath
// List registers, node memories, allocation and link update logic,
// output register.
// ============================================================================
module dlc_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dlc_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dlc_pkg::OUT_W-1:0]  m_tdata,
    input  dlc_pkg::cmd_t              cmd,
    output dlc_pkg::status_t           status
);

    localparam int IW = dlc_pkg::IDX_W;
    localparam int AW = dlc_pkg::ADDR_W;
    localparam int DW = dlc_pkg::DATA_WIDTH;

    logic [4:0]    op_reg;
    logic [31:0]   value_reg;
    logic [IW-1:0] head_reg, tail_reg, cur_reg, free_reg, fresh_reg;
    logic [IW-1:0] head_next, tail_next, cur_next, free_next, fresh_next;
    logic [IW-1:0] fnext_reg, nbr_reg, nbr2_reg;
    logic [DW-1:0] rdat_reg;
    logic          err_reg, rvalid_reg, err_next, rvalid_next;
    logic [31:0]   rv_reg;
    logic          out_valid_reg;
    logic [34:0]   out_reg;

    logic [IW-1:0] next_rdata, prev_rdata;
    logic [DW-1:0] data_rdata;
    logic [AW-1:0] next_ra, prev_ra, data_ra;

    logic          n1_we, n2_we, p1_we, p2_we, d_we;
    logic [IW-1:0] n1_a, n2_a, p1_a, p2_a, d_a;
    logic [IW-1:0] n1_d, n2_d, p1_d, p2_d;

    logic          head_ok, tail_ok, cur_ok, free_ok, a_ok, use_prev;
    logic [IW-1:0] a_n, nbr_n, nbr2_n, fnext_n, oth_after, oth_before;
    logic [DW-1:0] word;

    assign head_ok  = dlc_pkg::idx_ok(head_reg);
    assign tail_ok  = dlc_pkg::idx_ok(tail_reg);
    assign cur_ok   = dlc_pkg::idx_ok(cur_reg);
    assign free_ok  = dlc_pkg::idx_ok(free_reg);
    assign a_ok     = free_ok || (fresh_reg < IW'(dlc_pkg::CAPACITY));
    assign a_n      = free_ok ? free_reg : fresh_reg;
    assign nbr_n    = dlc_pkg::idx_ok(nbr_reg)   ? nbr_reg   : dlc_pkg::NIL;
    assign nbr2_n   = dlc_pkg::idx_ok(nbr2_reg)  ? nbr2_reg  : dlc_pkg::NIL;
    assign fnext_n  = dlc_pkg::idx_ok(fnext_reg) ? fnext_reg : dlc_pkg::NIL;
    assign oth_after  = (cur_reg == tail_reg) ? dlc_pkg::NIL : nbr_n;
    assign oth_before = (cur_reg == head_reg) ? dlc_pkg::NIL : nbr_n;
    assign word     = DW'($signed(value_reg));
    assign use_prev = (op_reg == dlc_pkg::OP_DEL_LAST)   || (op_reg == dlc_pkg::OP_DEL_BEFORE) ||
                      (op_reg == dlc_pkg::OP_INS_BEFORE) || (op_reg == dlc_pkg::OP_CUR_BACK);

    // read addresses
    always_comb
    begin
        next_ra = free_reg[AW-1:0];
        if (cmd.rd_nbr)
        begin
            next_ra = (op_reg == dlc_pkg::OP_DEL_FIRST) ? head_reg[AW-1:0] : cur_reg[AW-1:0];
        end
        if (cmd.rd_nbr2)
        begin
            next_ra = next_rdata[AW-1:0];
        end
        prev_ra = (op_reg == dlc_pkg::OP_DEL_LAST) ? tail_reg[AW-1:0] : cur_reg[AW-1:0];
        if (cmd.rd_nbr2)
        begin
            prev_ra = prev_rdata[AW-1:0];
        end
        case (op_reg)
            dlc_pkg::OP_READ_FIRST: data_ra = head_reg[AW-1:0];
            dlc_pkg::OP_READ_LAST:  data_ra = tail_reg[AW-1:0];
            default:                data_ra = cur_reg[AW-1:0];
        endcase
    end

    // operation decode: writes and next list state
    always_comb
    begin
        n1_we = 1'b0; n1_a = '0; n1_d = dlc_pkg::NIL;
        n2_we = 1'b0; n2_a = '0; n2_d = dlc_pkg::NIL;
        p1_we = 1'b0; p1_a = '0; p1_d = dlc_pkg::NIL;
        p2_we = 1'b0; p2_a = '0; p2_d = dlc_pkg::NIL;
        d_we  = 1'b0; d_a  = a_n;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cur_next    = cur_reg;
        free_next   = free_reg;
        fresh_next  = fresh_reg;
        err_next    = 1'b0;
        rvalid_next = 1'b0;
        case (op_reg)
            dlc_pkg::OP_CLEAR:
            begin
                if (head_ok)
                begin
                    n1_we = tail_ok; n1_a = tail_reg; n1_d = free_reg;
                    free_next = head_reg;
                end
                head_next = dlc_pkg::NIL;
                tail_next = dlc_pkg::NIL;
                cur_next  = dlc_pkg::NIL;
            end
            dlc_pkg::OP_INS_FIRST:
            begin
                if (!a_ok)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    d_we  = 1'b1;
                    n1_we = 1'b1; n1_a = a_n; n1_d = head_ok ? head_reg : dlc_pkg::NIL;
                    p1_we = 1'b1; p1_a = a_n; p1_d = dlc_pkg::NIL;
                    p2_we = head_ok; p2_a = head_reg; p2_d = a_n;
                    if (!head_ok)
                    begin
                        tail_next = a_n;
                    end
                    head_next = a_n;
                end
            end
            dlc_pkg::OP_INS_LAST:
            begin
                if (!a_ok)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    d_we  = 1'b1;
                    n1_we = 1'b1; n1_a = a_n; n1_d = dlc_pkg::NIL;
                    p1_we = 1'b1; p1_a = a_n; p1_d = tail_ok ? tail_reg : dlc_pkg::NIL;
                    n2_we = tail_ok; n2_a = tail_reg; n2_d = a_n;
                    if (!tail_ok)
                    begin
                        head_next = a_n;
                    end
                    tail_next = a_n;
                end
            end
            dlc_pkg::OP_CUR_FIRST: cur_next = head_reg;
            dlc_pkg::OP_CUR_LAST:  cur_next = tail_reg;
            dlc_pkg::OP_READ_FIRST, dlc_pkg::OP_READ_LAST:
            begin
                err_next    = !head_ok;
                rvalid_next = head_ok;
            end
            dlc_pkg::OP_DEL_FIRST:
            begin
                if (head_ok)
                begin
                    if (cur_reg == head_reg)
                    begin
                        cur_next = dlc_pkg::NIL;
                    end
                    if (tail_reg == head_reg)
                    begin
                        head_next = dlc_pkg::NIL;
                        tail_next = dlc_pkg::NIL;
                        cur_next  = dlc_pkg::NIL;
                    end
                    else
                    begin
                        p1_we = dlc_pkg::idx_ok(nbr_n); p1_a = nbr_n; p1_d = dlc_pkg::NIL;
                        head_next = nbr_n;
                    end
                    n2_we = 1'b1; n2_a = head_reg; n2_d = free_reg;
                    free_next = head_reg;
                end
            end
            dlc_pkg::OP_DEL_LAST:
            begin
                if (tail_ok)
                begin
                    if (cur_reg == tail_reg)
                    begin
                        cur_next = dlc_pkg::NIL;
                    end
                    if (head_reg == tail_reg)
                    begin
                        head_next = dlc_pkg::NIL;
                        tail_next = dlc_pkg::NIL;
                        cur_next  = dlc_pkg::NIL;
                    end
                    else
                    begin
                        n1_we = dlc_pkg::idx_ok(nbr_n); n1_a = nbr_n; n1_d = dlc_pkg::NIL;
                        tail_next = nbr_n;
                    end
                    n2_we = 1'b1; n2_a = tail_reg; n2_d = free_reg;
                    free_next = tail_reg;
                end
            end
            dlc_pkg::OP_DEL_AFTER:
            begin
                if (cur_ok && (cur_reg != tail_reg))
                begin
                    if (nbr_n == tail_reg)
                    begin
                        n1_we = 1'b1; n1_a = cur_reg; n1_d = dlc_pkg::NIL;
                        tail_next = cur_reg;
                    end
                    else
                    begin
                        n1_we = 1'b1; n1_a = cur_reg; n1_d = nbr2_n;
                        p1_we = dlc_pkg::idx_ok(nbr2_n); p1_a = nbr2_n; p1_d = cur_reg;
                    end
                    if (dlc_pkg::idx_ok(nbr_n))
                    begin
                        n2_we = 1'b1; n2_a = nbr_n; n2_d = free_reg;
                        free_next = nbr_n;
                    end
                end
            end
            dlc_pkg::OP_DEL_BEFORE:
            begin
                if (cur_ok && (cur_reg != head_reg))
                begin
                    if (nbr_n == head_reg)
                    begin
                        p1_we = 1'b1; p1_a = cur_reg; p1_d = dlc_pkg::NIL;
                        head_next = cur_reg;
                    end
                    else
                    begin
                        p1_we = 1'b1; p1_a = cur_reg; p1_d = nbr2_n;
                        n1_we = dlc_pkg::idx_ok(nbr2_n); n1_a = nbr2_n; n1_d = cur_reg;
                    end
                    if (dlc_pkg::idx_ok(nbr_n))
                    begin
                        n2_we = 1'b1; n2_a = nbr_n; n2_d = free_reg;
                        free_next = nbr_n;
                    end
                end
            end
            dlc_pkg::OP_INS_AFTER:
            begin
                if (cur_ok)
                begin
                    if (!a_ok)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        d_we  = 1'b1;
                        n1_we = 1'b1; n1_a = cur_reg; n1_d = a_n;
                        p1_we = 1'b1; p1_a = a_n; p1_d = cur_reg;
                        n2_we = 1'b1; n2_a = a_n; n2_d = oth_after;
                        if (dlc_pkg::idx_ok(oth_after))
                        begin
                            p2_we = 1'b1; p2_a = oth_after; p2_d = a_n;
                        end
                        else
                        begin
                            tail_next = a_n;
                        end
                    end
                end
            end
            dlc_pkg::OP_INS_BEFORE:
            begin
                if (cur_ok)
                begin
                    if (!a_ok)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        d_we  = 1'b1;
                        p1_we = 1'b1; p1_a = cur_reg; p1_d = a_n;
                        n1_we = 1'b1; n1_a = a_n; n1_d = cur_reg;
                        p2_we = 1'b1; p2_a = a_n; p2_d = oth_before;
                        if (dlc_pkg::idx_ok(oth_before))
                        begin
                            n2_we = 1'b1; n2_a = oth_before; n2_d = a_n;
                        end
                        else
                        begin
                            head_next = a_n;
                        end
                    end
                end
            end
            dlc_pkg::OP_READ_CUR:
            begin
                err_next    = !cur_ok;
                rvalid_next = cur_ok;
            end
            dlc_pkg::OP_OVERWRITE:
            begin
                d_we = cur_ok;
                d_a  = cur_reg;
            end
            dlc_pkg::OP_CUR_FWD, dlc_pkg::OP_CUR_BACK:
            begin
                if (cur_ok)
                begin
                    cur_next = nbr_n;
                end
            end
            default: ;
        endcase
        // allocation bookkeeping: any op that wrote a fresh node's data
        if (d_we && (op_reg != dlc_pkg::OP_OVERWRITE))
        begin
            if (free_ok)
            begin
                free_next = fnext_n;
            end
            else
            begin
                fresh_next = fresh_reg + IW'(1);
            end
        end
    end

    dlc_ram #(.WIDTH(IW), .DEPTH(dlc_pkg::CAPACITY)) u_next_ram (
        .clk   (clk),
        .we    ((cmd.wr1 && n1_we) || (cmd.wr2 && n2_we)),
        .waddr (cmd.wr1 ? n1_a[AW-1:0] : n2_a[AW-1:0]),
        .wdata (cmd.wr1 ? n1_d : n2_d),
        .raddr (next_ra),
        .rdata (next_rdata)
    );

    dlc_ram #(.WIDTH(IW), .DEPTH(dlc_pkg::CAPACITY)) u_prev_ram (
        .clk   (clk),
        .we    ((cmd.wr1 && p1_we) || (cmd.wr2 && p2_we)),
        .waddr (cmd.wr1 ? p1_a[AW-1:0] : p2_a[AW-1:0]),
        .wdata (cmd.wr1 ? p1_d : p2_d),
        .raddr (prev_ra),
        .rdata (prev_rdata)
    );

    dlc_ram #(.WIDTH(DW), .DEPTH(dlc_pkg::CAPACITY)) u_data_ram (
        .clk   (clk),
        .we    (cmd.wr1 && d_we),
        .waddr (d_a[AW-1:0]),
        .wdata (word),
        .raddr (data_ra),
        .rdata (data_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= s_tdata[4:0];
            value_reg <= s_tdata[36:5];
        end
        if (cmd.rd_nbr)
        begin
            fnext_reg <= next_rdata;
        end
        if (cmd.rd_nbr2)
        begin
            nbr_reg  <= use_prev ? prev_rdata : next_rdata;
            rdat_reg <= data_rdata;
        end
        if (cmd.cap2)
        begin
            nbr2_reg <= use_prev ? prev_rdata : next_rdata;
        end
        if (cmd.wr2)
        begin
            rv_reg <= rvalid_next ? 32'($signed(rdat_reg)) : 32'd0;
        end
        if (cmd.load_out)
        begin
            out_reg <= {err_reg, dlc_pkg::idx_ok(cur_reg), rvalid_reg, rv_reg};
        end
    end

    // list state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= dlc_pkg::NIL;
            tail_reg      <= dlc_pkg::NIL;
            cur_reg       <= dlc_pkg::NIL;
            free_reg      <= dlc_pkg::NIL;
            fresh_reg     <= '0;
            err_reg       <= 1'b0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr2)
            begin
                head_reg   <= head_next;
                tail_reg   <= tail_next;
                cur_reg    <= cur_next;
                free_reg   <= free_next;
                fresh_reg  <= fresh_next;
                err_reg    <= err_next;
                rvalid_reg <= rvalid_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {{(dlc_pkg::OUT_W - 35){1'b0}}, out_reg};

endmodule

// ----- src/doubly_linked_list_with_cursor_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// doubly_linked_list_with_cursor_core
// Bounded doubly linked list with head, tail and cursor over a node pool.
// ============================================================================
//  channel   direction  content
//  s_axis    in         opcode, value
//  m_axis    out        read_value, read_valid, is_active, error
//
//  An item is taken only in the idle state. Its result is formed in order by
//  three registered reads of the link memories, one capture, two write steps
//  on the single write ports, and the load of the output register. The next
//  item is taken only once that load is done; items do not overlap.
//  Reset empties the list at once; node memories need no clearing.
//  A waiting result does not block the next accept; a stalled result holds
//  only the final step of the following item.
// ============================================================================
module doubly_linked_list_with_cursor_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [dlc_pkg::IN_W-1:0]   s_tdata,   // opcode[4:0], value[36:5]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dlc_pkg::OUT_W-1:0]  m_tdata    // read_value[31:0], read_valid[32],
                                                  // is_active[33], error[34]
);

    dlc_pkg::cmd_t    cmd;
    dlc_pkg::status_t status;

    dlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    dlc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a second item while busy");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output loaded over an untaken result");

    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.rd_nbr, cmd.rd_nbr2, cmd.cap2, cmd.wr1, cmd.wr2,
                  cmd.load_out}))
        else $error("more than one sequencer phase active");

    a_read_or_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[32] && m_tdata[34]))
        else $error("read_valid and error both set");
`endif

endmodule

// ----- tb/tb_doubly_linked_list_with_cursor_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_doubly_linked_list_with_cursor_core
// Stream-level test of the linked-list core: directed and random list
// operations are checked item by item against a local model of the list.
// ============================================================================
module tb_doubly_linked_list_with_cursor_core;

    localparam int IW = dlc_pkg::IDX_W;
    localparam int AW = dlc_pkg::ADDR_W;

    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  opcode;
    } list_cmd_t;

    typedef struct packed {
        logic        error;
        logic        is_active;
        logic        read_valid;
        logic [31:0] read_value;
    } list_rsp_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [dlc_pkg::IN_W-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [dlc_pkg::OUT_W-1:0] m_tdata;
    logic                      in_acc;

    list_cmd_t cmd_queue[$];
    list_rsp_t rsp_expected[$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  hold_off = 0;
    int  send_gap = 0;
    int  stall_req = 0;
    int  stall_ack = 0;
    bit  pause_send = 1'b0;

    logic [31:0]   mdl_data [dlc_pkg::CAPACITY];
    logic [IW-1:0] mdl_next [dlc_pkg::CAPACITY];
    logic [IW-1:0] mdl_prev [dlc_pkg::CAPACITY];
    logic [IW-1:0] mdl_head  = dlc_pkg::NIL;
    logic [IW-1:0] mdl_tail  = dlc_pkg::NIL;
    logic [IW-1:0] mdl_cur   = dlc_pkg::NIL;
    logic [IW-1:0] mdl_free  = dlc_pkg::NIL;
    logic [IW-1:0] mdl_fresh = '0;

    doubly_linked_list_with_cursor_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit valid_idx(logic [IW-1:0] i);
        return i < IW'(dlc_pkg::CAPACITY);
    endfunction

    function automatic logic [IW-1:0] link_of(logic [IW-1:0] i, bit fwd);
        logic [IW-1:0] l;
        if (!valid_idx(i))
        begin
            return dlc_pkg::NIL;
        end
        l = fwd ? mdl_next[i[AW-1:0]] : mdl_prev[i[AW-1:0]];
        return valid_idx(l) ? l : dlc_pkg::NIL;
    endfunction

    function automatic void set_nxt(logic [IW-1:0] i, logic [IW-1:0] v);
        if (valid_idx(i))
        begin
            mdl_next[i[AW-1:0]] = v;
        end
    endfunction

    function automatic void set_prv(logic [IW-1:0] i, logic [IW-1:0] v);
        if (valid_idx(i))
        begin
            mdl_prev[i[AW-1:0]] = v;
        end
    endfunction

    function automatic logic [IW-1:0] take_node(logic [31:0] w);
        logic [IW-1:0] n;
        if (valid_idx(mdl_free))
        begin
            n = mdl_free;
            mdl_free = link_of(n, 1'b1);
        end
        else if (mdl_fresh < IW'(dlc_pkg::CAPACITY))
        begin
            n = mdl_fresh;
            mdl_fresh = mdl_fresh + IW'(1);
        end
        else
        begin
            return dlc_pkg::NIL;
        end
        mdl_data[n[AW-1:0]] = w;
        mdl_next[n[AW-1:0]] = dlc_pkg::NIL;
        mdl_prev[n[AW-1:0]] = dlc_pkg::NIL;
        return n;
    endfunction

    function automatic void give_node(logic [IW-1:0] i);
        if (valid_idx(i))
        begin
            mdl_next[i[AW-1:0]] = mdl_free;
            mdl_free = i;
        end
    endfunction

    function automatic list_rsp_t apply_list_op(list_cmd_t c);
        list_rsp_t r;
        logic [IW-1:0] n, d, o;
        r = '0;
        case (c.opcode)
            dlc_pkg::OP_CLEAR:
            begin
                if (valid_idx(mdl_head))
                begin
                    set_nxt(mdl_tail, mdl_free);
                    mdl_free = mdl_head;
                end
                mdl_head = dlc_pkg::NIL; mdl_tail = dlc_pkg::NIL; mdl_cur = dlc_pkg::NIL;
            end
            dlc_pkg::OP_INS_FIRST:
            begin
                n = take_node(c.value);
                if (!valid_idx(n)) r.error = 1'b1;
                else
                begin
                    if (!valid_idx(mdl_head)) mdl_tail = n;
                    else
                    begin
                        mdl_next[n[AW-1:0]] = mdl_head;
                        set_prv(mdl_head, n);
                    end
                    mdl_head = n;
                end
            end
            dlc_pkg::OP_INS_LAST:
            begin
                n = take_node(c.value);
                if (!valid_idx(n)) r.error = 1'b1;
                else
                begin
                    if (!valid_idx(mdl_tail)) mdl_head = n;
                    else
                    begin
                        mdl_prev[n[AW-1:0]] = mdl_tail;
                        set_nxt(mdl_tail, n);
                    end
                    mdl_tail = n;
                end
            end
            dlc_pkg::OP_CUR_FIRST: mdl_cur = mdl_head;
            dlc_pkg::OP_CUR_LAST:  mdl_cur = mdl_tail;
            dlc_pkg::OP_READ_FIRST, dlc_pkg::OP_READ_LAST:
            begin
                if (!valid_idx(mdl_head)) r.error = 1'b1;
                else
                begin
                    d = (c.opcode == dlc_pkg::OP_READ_FIRST) ? mdl_head : mdl_tail;
                    r.read_value = mdl_data[d[AW-1:0]];
                    r.read_valid = 1'b1;
                end
            end
            dlc_pkg::OP_DEL_FIRST:
            begin
                if (valid_idx(mdl_head))
                begin
                    d = mdl_head;
                    if (mdl_cur == d) mdl_cur = dlc_pkg::NIL;
                    if (mdl_tail == d)
                    begin
                        mdl_head = dlc_pkg::NIL; mdl_tail = dlc_pkg::NIL;
                        mdl_cur = dlc_pkg::NIL;
                    end
                    else
                    begin
                        o = link_of(d, 1'b1);
                        set_prv(o, dlc_pkg::NIL);
                        mdl_head = o;
                    end
                    give_node(d);
                end
            end
            dlc_pkg::OP_DEL_LAST:
            begin
                if (valid_idx(mdl_tail))
                begin
                    d = mdl_tail;
                    if (mdl_cur == d) mdl_cur = dlc_pkg::NIL;
                    if (mdl_head == d)
                    begin
                        mdl_head = dlc_pkg::NIL; mdl_tail = dlc_pkg::NIL;
                        mdl_cur = dlc_pkg::NIL;
                    end
                    else
                    begin
                        o = link_of(d, 1'b0);
                        set_nxt(o, dlc_pkg::NIL);
                        mdl_tail = o;
                    end
                    give_node(d);
                end
            end
            dlc_pkg::OP_DEL_AFTER:
            begin
                if (valid_idx(mdl_cur) && mdl_cur != mdl_tail)
                begin
                    d = link_of(mdl_cur, 1'b1);
                    if (d == mdl_tail)
                    begin
                        set_nxt(mdl_cur, dlc_pkg::NIL);
                        mdl_tail = mdl_cur;
                    end
                    else
                    begin
                        o = link_of(d, 1'b1);
                        set_nxt(mdl_cur, o);
                        set_prv(o, mdl_cur);
                    end
                    give_node(d);
                end
            end
            dlc_pkg::OP_DEL_BEFORE:
            begin
                if (valid_idx(mdl_cur) && mdl_cur != mdl_head)
                begin
                    d = link_of(mdl_cur, 1'b0);
                    if (d == mdl_head)
                    begin
                        set_prv(mdl_cur, dlc_pkg::NIL);
                        mdl_head = mdl_cur;
                    end
                    else
                    begin
                        o = link_of(d, 1'b0);
                        set_prv(mdl_cur, o);
                        set_nxt(o, mdl_cur);
                    end
                    give_node(d);
                end
            end
            dlc_pkg::OP_INS_AFTER:
            begin
                if (valid_idx(mdl_cur))
                begin
                    n = take_node(c.value);
                    if (!valid_idx(n)) r.error = 1'b1;
                    else
                    begin
                        o = (mdl_cur == mdl_tail) ? dlc_pkg::NIL : link_of(mdl_cur, 1'b1);
                        set_nxt(mdl_cur, n);
                        mdl_prev[n[AW-1:0]] = mdl_cur;
                        mdl_next[n[AW-1:0]] = o;
                        if (valid_idx(o)) set_prv(o, n);
                        else mdl_tail = n;
                    end
                end
            end
            dlc_pkg::OP_INS_BEFORE:
            begin
                if (valid_idx(mdl_cur))
                begin
                    n = take_node(c.value);
                    if (!valid_idx(n)) r.error = 1'b1;
                    else
                    begin
                        o = (mdl_cur == mdl_head) ? dlc_pkg::NIL : link_of(mdl_cur, 1'b0);
                        set_prv(mdl_cur, n);
                        mdl_next[n[AW-1:0]] = mdl_cur;
                        mdl_prev[n[AW-1:0]] = o;
                        if (valid_idx(o)) set_nxt(o, n);
                        else mdl_head = n;
                    end
                end
            end
            dlc_pkg::OP_READ_CUR:
            begin
                if (!valid_idx(mdl_cur)) r.error = 1'b1;
                else
                begin
                    r.read_value = mdl_data[mdl_cur[AW-1:0]];
                    r.read_valid = 1'b1;
                end
            end
            dlc_pkg::OP_OVERWRITE:
            begin
                if (valid_idx(mdl_cur)) mdl_data[mdl_cur[AW-1:0]] = c.value;
            end
            dlc_pkg::OP_CUR_FWD:
            begin
                if (valid_idx(mdl_cur)) mdl_cur = link_of(mdl_cur, 1'b1);
            end
            dlc_pkg::OP_CUR_BACK:
            begin
                if (valid_idx(mdl_cur)) mdl_cur = link_of(mdl_cur, 1'b0);
            end
            default: ;
        endcase
        r.is_active = valid_idx(mdl_cur);
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_cmd(logic [4:0] op, logic [31:0] v);
        list_cmd_t c;
        c.opcode = op;
        c.value = v;
        cmd_queue.push_back(c);
    endtask

    // input accept seen at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_acc <= 1'b0;
        end
        else
        begin
            in_acc <= s_tvalid && s_tready;
        end
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_acc)
            begin
                rsp_expected.push_back(apply_list_op(cmd_queue.pop_front()));
            end
            if (s_tvalid && !in_acc)
            begin
                // item still waiting
            end
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (cmd_queue.size() > 0 && !pause_send)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= dlc_pkg::IN_W'(cmd_queue[0]);
                if ($urandom_range(0, 3) == 0)
                begin
                    send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_off <= 0;
            stall_ack <= 0;
        end
        else if (stall_ack != stall_req)
        begin
            stall_ack <= stall_req;
            hold_off <= 60;
            m_tready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            if ($urandom_range(0, 15) == 0) hold_off <= $urandom_range(10, 40);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        list_rsp_t got, exp_rsp;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[34:0];
            if (rsp_expected.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end
            else
            begin
                exp_rsp = rsp_expected.pop_front();
                if (got.read_value !== exp_rsp.read_value)
                begin
                    $display("%0t: read_value exp %h got %h", $realtime,
                             exp_rsp.read_value, got.read_value);
                    errors++;
                end
                if (got.read_valid !== exp_rsp.read_valid)
                begin
                    $display("%0t: read_valid exp %b got %b", $realtime,
                             exp_rsp.read_valid, got.read_valid);
                    errors++;
                end
                if (got.is_active !== exp_rsp.is_active)
                begin
                    $display("%0t: is_active exp %b got %b", $realtime,
                             exp_rsp.is_active, got.is_active);
                    errors++;
                end
                if (got.error !== exp_rsp.error)
                begin
                    $display("%0t: error exp %b got %b", $realtime,
                             exp_rsp.error, got.error);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 5000)
            begin
                $display("tb_doubly_linked_list_with_cursor_core: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int k, op;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list corners, then every operation
        push_cmd(dlc_pkg::OP_READ_FIRST, 32'h0);
        push_cmd(dlc_pkg::OP_READ_CUR, 32'h0);
        push_cmd(dlc_pkg::OP_DEL_FIRST, 32'h0);
        push_cmd(dlc_pkg::OP_DEL_LAST, 32'h0);
        push_cmd(dlc_pkg::OP_INS_AFTER, 32'h1);
        push_cmd(dlc_pkg::OP_INS_FIRST, 32'h7FFF_FFFF);
        push_cmd(dlc_pkg::OP_INS_LAST, 32'h8000_0000);
        push_cmd(dlc_pkg::OP_CUR_FIRST, 32'h0);
        push_cmd(dlc_pkg::OP_INS_AFTER, 32'hFFFF_FFFF);
        push_cmd(dlc_pkg::OP_INS_BEFORE, 32'h0);
        push_cmd(dlc_pkg::OP_READ_CUR, 32'h0);
        push_cmd(dlc_pkg::OP_OVERWRITE, 32'h5A5A_A5A5);
        push_cmd(dlc_pkg::OP_READ_FIRST, 32'h0);
        push_cmd(dlc_pkg::OP_READ_LAST, 32'h0);
        push_cmd(dlc_pkg::OP_CUR_FWD, 32'h0);
        push_cmd(dlc_pkg::OP_DEL_BEFORE, 32'h0);
        push_cmd(dlc_pkg::OP_DEL_AFTER, 32'h0);
        push_cmd(dlc_pkg::OP_CUR_LAST, 32'h0);
        push_cmd(dlc_pkg::OP_CUR_FWD, 32'h0);
        push_cmd(dlc_pkg::OP_QUERY, 32'h0);
        push_cmd(dlc_pkg::OP_CUR_BACK, 32'h0);
        push_cmd(5'd31, 32'hFFFF_FFFF);
        push_cmd(dlc_pkg::OP_CLEAR, 32'h0);
        push_cmd(5'd18, 32'h0);

        // receiver stalls long while sender keeps offering
        stall_req++;
        for (k = 0; k < 20; k++) push_cmd(dlc_pkg::OP_INS_LAST, $urandom);
        wait (cmd_queue.size() == 0);

        // exhaust the pool
        for (k = 0; k < dlc_pkg::CAPACITY + 4; k++)
        begin
            push_cmd(dlc_pkg::OP_INS_FIRST, rand_word());
        end
        push_cmd(dlc_pkg::OP_CUR_FIRST, 32'h0);
        push_cmd(dlc_pkg::OP_INS_AFTER, 32'h1);
        push_cmd(dlc_pkg::OP_INS_BEFORE, 32'h2);
        push_cmd(dlc_pkg::OP_CLEAR, 32'h0);

        // sender pauses until the block drains
        wait (cmd_queue.size() == 0);
        pause_send = 1'b1;
        wait (rsp_expected.size() == 0 && !s_tvalid);
        pause_send = 1'b0;

        // random: mostly structural ops with occasional clears and junk opcodes
        for (k = 0; k < 1200; k++)
        begin
            op = $urandom_range(0, 99);
            if (op < 1) push_cmd(dlc_pkg::OP_CLEAR, 32'h0);
            else if (op < 3) push_cmd(5'($urandom_range(18, 31)), $urandom);
            else push_cmd(5'($urandom_range(1, 17)), rand_word());
            if (k % 200 == 199) wait (cmd_queue.size() < 20);
        end

        wait (cmd_queue.size() == 0 && rsp_expected.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_doubly_linked_list_with_cursor_core: PASS");
        end
        else
        begin
            $display("tb_doubly_linked_list_with_cursor_core: FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
src/dlc_pkg.sv
src/dlc_ram.sv
src/dlc_ctrl.sv
src/dlc_datapath.sv
src/doubly_linked_list_with_cursor_core.sv
tb/tb_doubly_linked_list_with_cursor_core.sv
